>>> sv/hlfr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hlfr_pkg
// Shared types and constants for the header/length frame receiver.
// ============================================================================
package hlfr_pkg;

    // Default frame buffer depth in bytes
    localparam int MAX_FRAME_DEF = 64;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int CFG_IDX_W = 1;

    // Header reset values
    localparam logic [BYTE_W-1:0] FIRST_HDR_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_HDR_RST = 8'h55;

    // Input item kinds (carried on tuser)
    typedef enum logic [OP_W-1:0] {
        OP_BYTE     = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_LINE_ERR = 2'd2
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_HDR  = 1'b0,
        CFG_SECOND_HDR = 1'b1
    } cfg_idx_t;

    // Parser phases
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HEAD = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

endpackage

>>> sv/hlfr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// hlfr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/hlfr_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// hlfr_parser
// Header/length parser: tracks phase and count, writes frame bytes into the
// store and requests a readout when the count reaches the declared length.
// ============================================================================
module hlfr_parser #(
    parameter int MAX_FRAME = hlfr_pkg::MAX_FRAME_DEF,
    parameter int ADDR_W    = 6,
    parameter int CNT_W     = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // accepted input transfer
    input  logic                             in_acc,
    input  logic [hlfr_pkg::OP_W-1:0]        in_op,
    input  logic [hlfr_pkg::BYTE_W-1:0]      in_byte,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [hlfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hlfr_pkg::BYTE_W-1:0]      cfg_wdata,
    // store write port
    output logic                             wr_en,
    output logic [ADDR_W-1:0]                wr_addr,
    output logic [hlfr_pkg::BYTE_W-1:0]      wr_data,
    // readout request
    output logic                             emit_start,
    output logic [CNT_W-1:0]                 emit_len
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

    hlfr_pkg::phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [hlfr_pkg::BYTE_W-1:0]    dlen_reg, dlen_next;
    logic                           ready_reg, ready_next;
    logic [hlfr_pkg::BYTE_W-1:0]    hdr1_reg, hdr2_reg;

    logic                           byte_acc;
    logic                           room;
    logic [CNT_W-1:0]               count_inc;
    logic                           len_hit;

    // Shared decode
    assign byte_acc  = in_acc && (in_op == hlfr_pkg::OP_BYTE) && !ready_reg;
    assign room      = (count_reg < CNT_MAX);
    assign count_inc = count_reg + CNT_W'(1);
    assign len_hit   = (hlfr_pkg::BYTE_W'(count_inc) == dlen_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr1_reg <= hlfr_pkg::FIRST_HDR_RST;
            hdr2_reg <= hlfr_pkg::SECOND_HDR_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hlfr_pkg::CFG_FIRST_HDR:  hdr1_reg <= cfg_wdata;
                hlfr_pkg::CFG_SECOND_HDR: hdr2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        dlen_next  = dlen_reg;
        ready_next = ready_reg;
        if (in_acc) begin
            case (in_op)
                hlfr_pkg::OP_RELEASE: ready_next = 1'b0;
                hlfr_pkg::OP_LINE_ERR: begin
                    phase_next = hlfr_pkg::PH_IDLE;
                    count_next = '0;
                end
                default: ;
            endcase
        end
        if (byte_acc) begin
            unique case (phase_reg)
                hlfr_pkg::PH_IDLE: begin
                    if (in_byte == hdr1_reg) begin
                        count_next = CNT_W'(1);
                        phase_next = hlfr_pkg::PH_HEAD;
                    end
                end
                hlfr_pkg::PH_HEAD: begin
                    if (in_byte == hdr2_reg) begin
                        if (room) count_next = count_inc;
                        phase_next = hlfr_pkg::PH_LEN;
                    end else begin
                        phase_next = hlfr_pkg::PH_IDLE;
                    end
                end
                hlfr_pkg::PH_LEN: begin
                    if (room) count_next = count_inc;
                    dlen_next  = in_byte;
                    phase_next = hlfr_pkg::PH_DATA;
                end
                hlfr_pkg::PH_DATA: begin
                    if (!room) begin
                        // buffer full: drop the frame
                        phase_next = hlfr_pkg::PH_IDLE;
                    end else begin
                        count_next = count_inc;
                        if (len_hit) begin
                            ready_next = 1'b1;
                            phase_next = hlfr_pkg::PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Outputs: store writes and readout request
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = in_byte;
        emit_start = 1'b0;
        emit_len   = count_inc;
        if (byte_acc) begin
            unique case (phase_reg)
                hlfr_pkg::PH_IDLE: begin
                    wr_en   = (in_byte == hdr1_reg);
                    wr_addr = '0;
                end
                hlfr_pkg::PH_HEAD: wr_en = (in_byte == hdr2_reg) && room;
                hlfr_pkg::PH_LEN:  wr_en = room;
                hlfr_pkg::PH_DATA: begin
                    wr_en      = room;
                    emit_start = room && len_hit;
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hlfr_pkg::PH_IDLE;
            count_reg <= '0;
            dlen_reg  <= '0;
            ready_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            dlen_reg  <= dlen_next;
            ready_reg <= ready_next;
        end
    end

endmodule

>>> sv/hlfr_readout.sv
`timescale 1ns / 1ps
// ============================================================================
// hlfr_readout
// Frame readout: walks the store from address zero, one read per cycle unless
// stalled, and drives results through a read-data stage and an output register.
// ============================================================================
module hlfr_readout #(
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request from the parser
    input  logic                           emit_start,
    input  logic [CNT_W-1:0]               emit_len,
    output logic                           busy,
    // store read port
    output logic                           rd_en,
    output logic [ADDR_W-1:0]              rd_addr,
    input  logic [hlfr_pkg::BYTE_W-1:0]    rd_data,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hlfr_pkg::BYTE_W-1:0]    m_byte,
    output logic [hlfr_pkg::IDX_W-1:0]     m_idx,
    output logic                           m_last
);

    logic                           act_reg;
    logic [ADDR_W-1:0]              raddr_reg;
    logic [CNT_W-1:0]               len_reg;
    logic                           s1_valid_reg;
    logic [ADDR_W-1:0]              s1_idx_reg;
    logic                           s1_last_reg;
    logic                           m_valid_reg;
    logic [hlfr_pkg::BYTE_W-1:0]    m_byte_reg;
    logic [hlfr_pkg::IDX_W-1:0]     m_idx_reg;
    logic                           m_last_reg;

    logic                           load_out;
    logic                           adv;
    logic                           issue;
    logic                           is_last;

    // Pipeline advance control
    assign load_out = !m_valid_reg || m_ready;
    assign adv      = !s1_valid_reg || load_out;
    assign issue    = act_reg && adv;
    assign is_last  = ((CNT_W'(raddr_reg) + CNT_W'(1)) == len_reg);

    assign rd_en   = issue;
    assign rd_addr = raddr_reg;
    assign busy    = act_reg;

    // Address sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else if (emit_start) begin
            act_reg <= 1'b1;
        end else if (issue && is_last) begin
            act_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_start) begin
            raddr_reg <= '0;
            len_reg   <= emit_len;
        end else if (issue) begin
            raddr_reg <= raddr_reg + ADDR_W'(1);
        end
    end

    // Read-data stage tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_idx_reg  <= raddr_reg;
            s1_last_reg <= is_last;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out && s1_valid_reg) begin
            m_byte_reg <= rd_data;
            m_idx_reg  <= hlfr_pkg::IDX_W'(s1_idx_reg);
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_idx   = m_idx_reg;
    assign m_last  = m_last_reg;

endmodule

>>> sv/header_length_frame_receiver.sv
`timescale 1ns / 1ps
// ============================================================================
// header_length_frame_receiver
// Byte-stream frame receiver with two header bytes and a length byte.
// ============================================================================
// Usage:
//   s_ channel: one transfer per item. s_tuser carries the item kind (byte,
//   release, line error), s_tdata the received byte.
//   m_ channel: one transfer per frame byte, headers included, in order,
//   with the byte position in m_tdata and m_tlast on the final byte.
//   cfg_we/cfg_index/cfg_wdata set the two header values; write while idle.
// Timing:
//   Ordinary items are taken whenever no readout runs. The byte that
//   completes a frame of N bytes starts a readout of the frame store; each
//   result passes the store's read data register and the output register, one per
//   cycle while m_tready is high. s_tready is low during reads (one read port).
// Reset:
//   aresetn low clears phase, count, length, ready flag and both channels;
//   headers return to 0xAA and 0x55. The store itself is not cleared.
// Stall:
//   While m_tready is low the output and read-data stages hold and the
//   store reads pause; nothing is lost.
// ============================================================================
module header_length_frame_receiver #(
    parameter int MAX_FRAME = hlfr_pkg::MAX_FRAME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                      s_tuser,   // [1:0] operation
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [7:0] frame_byte,
                                                       // [13:8] byte_index
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_we,
    input  logic [hlfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_wdata
);

    localparam int ADDR_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);

    logic                           in_acc;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [hlfr_pkg::BYTE_W-1:0]    wr_data;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [hlfr_pkg::BYTE_W-1:0]    rd_data;
    logic                           emit_start;
    logic [CNT_W-1:0]               emit_len;
    logic                           busy;
    logic [hlfr_pkg::BYTE_W-1:0]    out_byte;
    logic [hlfr_pkg::IDX_W-1:0]     out_idx;

    // Input is held off while the store is being read out
    assign s_tready = !busy;
    assign in_acc   = s_tvalid && !busy;

    hlfr_parser #(
        .MAX_FRAME (MAX_FRAME),
        .ADDR_W    (ADDR_W),
        .CNT_W     (CNT_W)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_acc     (in_acc),
        .in_op      (s_tuser),
        .in_byte    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .emit_start (emit_start),
        .emit_len   (emit_len)
    );

    hlfr_ram #(
        .WIDTH (hlfr_pkg::BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    hlfr_readout #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_readout (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit_start (emit_start),
        .emit_len   (emit_len),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_byte     (out_byte),
        .m_idx      (out_idx),
        .m_last     (m_tlast)
    );

    // Pack result fields, upper bits zero
    assign m_tdata = {2'b00, out_idx, out_byte};

endmodule

>>> sv/hlfr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hlfr_checker
// Port-level checks on the result channel of the frame receiver.
// ============================================================================
module hlfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // Stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Inside a frame the next byte follows at once with the next position
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[13:8] == ($past(m_tdata[13:8]) + 6'd1)))
        else $error("frame burst broken");

    // After the final byte, any next result opens a new frame
    a_new_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[13:8] == 6'd0))
        else $error("new frame does not start at position zero");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind header_length_frame_receiver hlfr_checker u_hlfr_checker (.*);
